[src/adi_gr_pkg.sv]
// adi_gr_pkg: shared types, constants and helpers of the grid relaxation core
// depends on nothing; used by the interfaces, the memory, the sweep engine and the top level
`default_nettype none

package adi_gr_pkg;

	// grid geometry
	localparam int GRID_SIDE = 16;
	localparam int COORD_W   = $clog2(GRID_SIDE);
	localparam int ADDR_W    = 3 * COORD_W;
	localparam int CELLS     = 2 ** ADDR_W;
	localparam logic [COORD_W-1:0] COORD_FIRST = COORD_W'(1);
	localparam logic [COORD_W-1:0] COORD_LAST  = COORD_W'(GRID_SIDE - 2);

	// field widths
	localparam int OP_W    = 2;
	localparam int IN_CO_W = 4;
	localparam int CELL_W  = 48;
	localparam int CHG_W   = 47;
	localparam int ITER_W  = 10;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b1;
	localparam logic [CHG_W-1:0]  THRESHOLD_RESET = CHG_W'(43);
	localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = ITER_W'(100);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// one memory access: one write port, two read ports
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} mem_req_t;

	// outcome of one run
	typedef struct packed {
		logic [ITER_W-1:0] iterations;
		logic [CHG_W-1:0]  change;
		logic              converged;
	} run_status_t;

	// cell address from three coordinates, i major
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] c);
		return {a, b, c};
	endfunction

	// floor of the mean of two cells; the 49-bit sum shifted right always fits
	function automatic logic [CELL_W-1:0] half_sum(input logic [CELL_W-1:0] x,
		input logic [CELL_W-1:0] y);
		logic [CELL_W:0] s;
		s = {x[CELL_W-1], x} + {y[CELL_W-1], y};
		return s[CELL_W:1];
	endfunction

endpackage

`default_nettype wire

[src/adi_gr_if.sv]
// adi_gr_cmd_if and adi_gr_rsp_if: valid/ready channels of the relaxation core
// depends on adi_gr_pkg for the field widths
`default_nettype none

interface adi_gr_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [adi_gr_pkg::OP_W-1:0]       opcode;
	logic [adi_gr_pkg::IN_CO_W-1:0]    coord_i;
	logic [adi_gr_pkg::IN_CO_W-1:0]    coord_j;
	logic [adi_gr_pkg::IN_CO_W-1:0]    coord_k;
	logic signed [adi_gr_pkg::CELL_W-1:0] cell_value;

	modport source (output valid, opcode, coord_i, coord_j, coord_k, cell_value, input ready);
	modport sink (input valid, opcode, coord_i, coord_j, coord_k, cell_value, output ready);
endinterface

interface adi_gr_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [adi_gr_pkg::CELL_W-1:0] read_value;
	logic [adi_gr_pkg::ITER_W-1:0]     iterations_done;
	logic [adi_gr_pkg::CHG_W-1:0]      final_change;
	logic                              converged;

	modport source (output valid, read_value, iterations_done, final_change, converged,
		input ready);
	modport sink (input valid, read_value, iterations_done, final_change, converged,
		output ready);
endinterface

`default_nettype wire

[src/adi_grid_relaxation_core.sv]
// adi_grid_relaxation_core: top level of the grid relaxation block
// depends on adi_gr_pkg, adi_gr_if, adi_gr_grid_mem and adi_gr_sweep
//
// Usage:
//   cmd carries one item per handshake: opcode, coord_i/j/k and cell_value.
//   Write items load a cell, read items return it, run items relax the grid.
//   rsp carries exactly one item for every command item, in order: the read
//   value (zero unless a read inside the grid) and the status of the last run.
//   cfg_wen/cfg_index/cfg_wdata set the change threshold (index 0) and the
//   iteration limit (index 1); write them only while the block is idle.
// Flow:
//   writes, reads and no-ops stream at one item per cycle while rsp takes
//   its items; each result passes stage 1 (memory read) and then the result
//   register. A run holds cmd.ready low while it walks the grid through the
//   single write port, one sweep after another.
// Reset clears the run status, restores the registers to their defaults and
// empties the pipeline; the grid contents are undefined until written.
// A stalled rsp holds its item; one more command item may enter behind it,
// then cmd.ready drops until the result is taken.
`default_nettype none

module adi_grid_relaxation_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	adi_gr_cmd_if.sink                             cmd,
	adi_gr_rsp_if.source                           rsp,
	input  wire logic                              cfg_wen,
	input  wire logic [adi_gr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [adi_gr_pkg::CHG_W-1:0]      cfg_wdata
);

	// configuration and run status
	logic [adi_gr_pkg::CHG_W-1:0]  threshold_q;
	logic [adi_gr_pkg::ITER_W-1:0] iter_limit_q;
	adi_gr_pkg::run_status_t       last_q;

	// pipeline
	logic                     run_q;
	logic                     valid_s1;
	adi_gr_pkg::opcode_t      op_s1;
	logic                     inside_s1;
	logic                     rsp_valid_q;
	logic [adi_gr_pkg::CELL_W-1:0] rsp_value_q;
	adi_gr_pkg::run_status_t  rsp_status_q;

	adi_gr_pkg::opcode_t      op;
	logic                     in_grid;
	logic                     accept;
	logic                     s1_go;
	logic [adi_gr_pkg::ADDR_W-1:0] cmd_addr;
	adi_gr_pkg::mem_req_t     cmd_req;
	adi_gr_pkg::mem_req_t     sweep_req;
	adi_gr_pkg::mem_req_t     mem_req;
	logic [adi_gr_pkg::CELL_W-1:0] rdata_a, rdata_b;
	logic                     sweep_done;
	adi_gr_pkg::run_status_t  sweep_status;

	// command decode
	assign op     = adi_gr_pkg::opcode_t'(cmd.opcode);
	assign in_grid = (32'(cmd.coord_i) < adi_gr_pkg::GRID_SIDE)
		&& (32'(cmd.coord_j) < adi_gr_pkg::GRID_SIDE)
		&& (32'(cmd.coord_k) < adi_gr_pkg::GRID_SIDE);
	assign cmd_addr = adi_gr_pkg::cell_addr(adi_gr_pkg::COORD_W'(cmd.coord_i),
		adi_gr_pkg::COORD_W'(cmd.coord_j), adi_gr_pkg::COORD_W'(cmd.coord_k));

	// handshake: stage 1 moves on once a run is over and the result slot frees
	assign s1_go     = valid_s1 && !run_q && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !run_q && (!valid_s1 || s1_go);
	assign accept    = cmd.valid && cmd.ready;

	// memory access of a command item
	always_comb begin
		cmd_req         = '0;
		cmd_req.waddr   = cmd_addr;
		cmd_req.wdata   = cmd.cell_value;
		cmd_req.raddr_a = cmd_addr;
		cmd_req.raddr_b = cmd_addr;
		cmd_req.we      = accept && (op == adi_gr_pkg::OP_WRITE) && in_grid;
		cmd_req.re      = accept && (op == adi_gr_pkg::OP_READ);
	end

	assign mem_req = run_q ? sweep_req : cmd_req;

	adi_gr_grid_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	adi_gr_sweep u_sweep (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (accept && (op == adi_gr_pkg::OP_RUN)),
		.change_threshold (threshold_q),
		.iteration_limit  (iter_limit_q),
		.rdata_a          (rdata_a),
		.rdata_b          (rdata_b),
		.req              (sweep_req),
		.done             (sweep_done),
		.status           (sweep_status)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= adi_gr_pkg::THRESHOLD_RESET;
			iter_limit_q <= adi_gr_pkg::ITER_LIMIT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				adi_gr_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_wdata;
				adi_gr_pkg::CFG_ITER_LIMIT: iter_limit_q <= adi_gr_pkg::ITER_W'(cfg_wdata);
				default: begin
					threshold_q <= threshold_q;
				end
			endcase
		end
	end

	// run tracking and status of the last run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			last_q <= '0;
		end else begin
			if (accept && (op == adi_gr_pkg::OP_RUN)) begin
				run_q <= 1'b1;
			end else if (sweep_done) begin
				run_q <= 1'b0;
			end
			if (sweep_done) begin
				last_q <= sweep_status;
			end
		end
	end

	// stage 1: waits for the memory read or for the end of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			inside_s1 <= in_grid;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			rsp_value_q  <= ((op_s1 == adi_gr_pkg::OP_READ) && inside_s1) ? rdata_a : '0;
			rsp_status_q <= last_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.read_value      = rsp_value_q;
	assign rsp.iterations_done = rsp_status_q.iterations;
	assign rsp.final_change    = rsp_status_q.change;
	assign rsp.converged       = rsp_status_q.converged;

	// a run ends only while one is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		sweep_done |-> run_q)
		else $error("sweep finished without a run");

	// only a read inside the grid gives a nonzero read value
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !((op_s1 == adi_gr_pkg::OP_READ) && inside_s1)) |=> (rsp.read_value == '0))
		else $error("nonzero read value on a non-read item");

	// no command item is taken while a run is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !cmd.ready)
		else $error("command item taken during a run");

endmodule

`default_nettype wire

[src/adi_gr_grid_mem.sv]
// adi_gr_grid_mem: cell store, one write port and two registered read ports
// depends on adi_gr_pkg for mem_req_t and the grid size
`default_nettype none

module adi_gr_grid_mem (
	input  wire logic                          clk,
	input  wire adi_gr_pkg::mem_req_t          req,
	output logic [adi_gr_pkg::CELL_W-1:0]      rdata_a,
	output logic [adi_gr_pkg::CELL_W-1:0]      rdata_b
);

	logic [adi_gr_pkg::CELL_W-1:0] cells_q [adi_gr_pkg::CELLS];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			cells_q[req.waddr] <= req.wdata;
		end
	end

	// read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_a <= cells_q[req.raddr_a];
			rdata_b <= cells_q[req.raddr_b];
		end
	end

endmodule

`default_nettype wire

[src/adi_gr_sweep.sv]
// adi_gr_sweep: run sequencer, walks the interior along i, j and k in place
// depends on adi_gr_pkg; drives the grid memory while a run is active
`default_nettype none

module adi_gr_sweep (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [adi_gr_pkg::CHG_W-1:0]  change_threshold,
	input  wire logic [adi_gr_pkg::ITER_W-1:0] iteration_limit,
	input  wire logic [adi_gr_pkg::CELL_W-1:0] rdata_a,
	input  wire logic [adi_gr_pkg::CELL_W-1:0] rdata_b,
	output adi_gr_pkg::mem_req_t               req,
	output logic                               done,
	output adi_gr_pkg::run_status_t            status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_HALF,
		S_KWR,
		S_DRAIN,
		S_CHECK
	} state_t;

	typedef enum logic [1:0] {
		PASS_I,
		PASS_J,
		PASS_K
	} pass_t;

	state_t state_q;
	pass_t  pass_q;
	logic [adi_gr_pkg::COORD_W-1:0] u_q, v_q, w_q;
	logic [adi_gr_pkg::ITER_W-1:0]  iter_q;
	logic [adi_gr_pkg::CELL_W-1:0]  big_q;
	logic                           absd_vld_q;
	logic [adi_gr_pkg::CELL_W-1:0]  nw_q;
	logic [adi_gr_pkg::CELL_W-1:0]  absd_q;

	logic [adi_gr_pkg::COORD_W-1:0] u_dn, u_up;
	logic [adi_gr_pkg::ADDR_W-1:0]  addr_lo, addr_hi, addr_mid;
	logic [adi_gr_pkg::CELL_W-1:0]  half;
	logic [adi_gr_pkg::CELL_W-1:0]  absd;
	logic [adi_gr_pkg::ITER_W-1:0]  iter_next;
	logic w_last, v_last, u_last, pass_end;
	logic below;

	// neighbor addresses along the swept axis
	assign u_dn = u_q - adi_gr_pkg::COORD_W'(1);
	assign u_up = u_q + adi_gr_pkg::COORD_W'(1);

	always_comb begin
		case (pass_q)
			PASS_I: begin
				addr_lo  = adi_gr_pkg::cell_addr(u_dn, v_q, w_q);
				addr_hi  = adi_gr_pkg::cell_addr(u_up, v_q, w_q);
				addr_mid = adi_gr_pkg::cell_addr(u_q, v_q, w_q);
			end
			PASS_J: begin
				addr_lo  = adi_gr_pkg::cell_addr(v_q, u_dn, w_q);
				addr_hi  = adi_gr_pkg::cell_addr(v_q, u_up, w_q);
				addr_mid = adi_gr_pkg::cell_addr(v_q, u_q, w_q);
			end
			default: begin
				addr_lo  = adi_gr_pkg::cell_addr(v_q, w_q, u_dn);
				addr_hi  = adi_gr_pkg::cell_addr(v_q, w_q, u_up);
				addr_mid = adi_gr_pkg::cell_addr(v_q, w_q, u_q);
			end
		endcase
	end

	// new value and absolute change of the k pass
	assign half = adi_gr_pkg::half_sum(rdata_a, rdata_b);
	assign absd = ($signed(rdata_a) >= $signed(nw_q)) ? (rdata_a - nw_q) : (nw_q - rdata_a);

	assign w_last   = (w_q == adi_gr_pkg::COORD_LAST);
	assign v_last   = (v_q == adi_gr_pkg::COORD_LAST);
	assign u_last   = (u_q == adi_gr_pkg::COORD_LAST);
	assign pass_end = w_last && v_last && u_last;

	assign iter_next = iter_q + adi_gr_pkg::ITER_W'(1);
	assign below     = (big_q < {1'b0, change_threshold});

	// memory accesses per state
	always_comb begin
		req         = '0;
		req.raddr_a = addr_lo;
		req.raddr_b = addr_hi;
		req.waddr   = addr_mid;
		case (state_q)
			S_RD: begin
				req.re = 1'b1;
			end
			S_HALF: begin
				if (pass_q == PASS_K) begin
					req.re      = 1'b1;
					req.raddr_a = addr_mid;
				end else begin
					req.we    = 1'b1;
					req.wdata = half;
				end
			end
			S_KWR: begin
				req.we    = 1'b1;
				req.wdata = nw_q;
			end
			default: begin
				req.re = 1'b0;
			end
		endcase
	end

	// sequencer state, counters, running maximum and run status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pass_q     <= PASS_I;
			u_q        <= adi_gr_pkg::COORD_FIRST;
			v_q        <= adi_gr_pkg::COORD_FIRST;
			w_q        <= adi_gr_pkg::COORD_FIRST;
			iter_q     <= '0;
			big_q      <= '0;
			absd_vld_q <= 1'b0;
			done       <= 1'b0;
			status     <= '0;
		end else begin
			done       <= 1'b0;
			absd_vld_q <= 1'b0;
			if (absd_vld_q && (absd_q > big_q)) begin
				big_q <= absd_q;
			end
			// step to the next interior cell at the end of each cell's work
			if ((state_q == S_KWR) || ((state_q == S_HALF) && (pass_q != PASS_K))) begin
				if (!w_last) begin
					w_q <= w_q + adi_gr_pkg::COORD_W'(1);
				end else begin
					w_q <= adi_gr_pkg::COORD_FIRST;
					if (!v_last) begin
						v_q <= v_q + adi_gr_pkg::COORD_W'(1);
					end else begin
						v_q <= adi_gr_pkg::COORD_FIRST;
						if (!u_last) begin
							u_q <= u_q + adi_gr_pkg::COORD_W'(1);
						end else begin
							u_q <= adi_gr_pkg::COORD_FIRST;
						end
					end
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						iter_q <= '0;
						big_q  <= '0;
						pass_q <= PASS_I;
						u_q    <= adi_gr_pkg::COORD_FIRST;
						v_q    <= adi_gr_pkg::COORD_FIRST;
						w_q    <= adi_gr_pkg::COORD_FIRST;
						if (iteration_limit == '0) begin
							done   <= 1'b1;
							status <= '0;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_HALF;
				end
				S_HALF: begin
					if (pass_q == PASS_K) begin
						state_q <= S_KWR;
					end else begin
						state_q <= S_RD;
						if (pass_end) begin
							pass_q <= (pass_q == PASS_I) ? PASS_J : PASS_K;
						end
					end
				end
				S_KWR: begin
					absd_vld_q <= 1'b1;
					state_q    <= pass_end ? S_DRAIN : S_RD;
				end
				S_DRAIN: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (below || (iter_next == iteration_limit)) begin
						state_q           <= S_IDLE;
						done              <= 1'b1;
						status.iterations <= iter_next;
						status.change     <= big_q[adi_gr_pkg::CELL_W-1] ? '1
							: big_q[adi_gr_pkg::CHG_W-1:0];
						status.converged  <= below;
					end else begin
						state_q <= S_RD;
						iter_q  <= iter_next;
						big_q   <= '0;
						pass_q  <= PASS_I;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the k pass
	always_ff @(posedge clk) begin
		if ((state_q == S_HALF) && (pass_q == PASS_K)) begin
			nw_q <= half;
		end
		if (state_q == S_KWR) begin
			absd_q <= absd;
		end
	end

	// the memory is left alone between runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!req.we && !req.re))
		else $error("sweep touches the grid while idle");

	// a run ends with exactly one done pulse
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// the walk stays inside the interior
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> ((u_q >= adi_gr_pkg::COORD_FIRST) && (u_q <= adi_gr_pkg::COORD_LAST)
		&& (v_q >= adi_gr_pkg::COORD_FIRST) && (v_q <= adi_gr_pkg::COORD_LAST)
		&& (w_q >= adi_gr_pkg::COORD_FIRST) && (w_q <= adi_gr_pkg::COORD_LAST)))
		else $error("sweep counter left the interior");

endmodule

`default_nettype wire

[tb/adi_grid_relaxation_core_tb.sv]
// adi_grid_relaxation_core_tb: self-checking bench for the grid relaxation core
// drives cell loads, reads and relaxation runs, predicts every reply with a local grid
// model and checks it field by field; depends on adi_gr_pkg and adi_gr_if
`timescale 1ns / 100ps

module adi_grid_relaxation_core_tb;

	localparam int unsigned RUN_CYCLE_LIMIT = 6_000_000;
	localparam int PHASE_ITEMS = 120;
	localparam int PHASE_COUNT = 12;

	typedef struct {
		logic [adi_gr_pkg::CELL_W-1:0] read_value;
		logic [adi_gr_pkg::ITER_W-1:0] iterations;
		logic [adi_gr_pkg::CHG_W-1:0]  change;
		logic                          converged;
	} grid_reply_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [adi_gr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [adi_gr_pkg::CHG_W-1:0] cfg_wdata;

	adi_gr_cmd_if cmd_ch ();
	adi_gr_rsp_if rsp_ch ();

	adi_grid_relaxation_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// grid model state, cells kept sign-extended
	longint cell_mem [adi_gr_pkg::CELLS];
	logic [adi_gr_pkg::ITER_W-1:0] run_iters;
	logic [adi_gr_pkg::CHG_W-1:0] run_change;
	logic run_conv;
	logic [adi_gr_pkg::CHG_W-1:0] thr_shadow;
	logic [adi_gr_pkg::ITER_W-1:0] limit_shadow;

	grid_reply_t grid_reply_q [$];
	int mismatches = 0;
	int unsigned cycle_count = 0;
	bit idle_on = 1'b1;
	int stall_left = 0;

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- grid model

	function automatic int cidx(int a, int b, int c);
		return (a * adi_gr_pkg::GRID_SIDE + b) * adi_gr_pkg::GRID_SIDE + c;
	endfunction

	// floor of the mean; longint holds the 49-bit sum exactly
	function automatic longint floor_mean(longint x, longint y);
		return (x + y) >>> 1;
	endfunction

	// one i, j, k pass over the interior; returns the largest k-pass change
	function automatic longint model_sweep();
		longint big;
		longint old_v;
		longint new_v;
		longint d;
		int p;
		big = 0;
		for (int a = 1; a <= adi_gr_pkg::GRID_SIDE - 2; a++)
			for (int b = 1; b <= adi_gr_pkg::GRID_SIDE - 2; b++)
				for (int c = 1; c <= adi_gr_pkg::GRID_SIDE - 2; c++)
					cell_mem[cidx(a, b, c)] = floor_mean(cell_mem[cidx(a - 1, b, c)],
						cell_mem[cidx(a + 1, b, c)]);
		for (int b = 1; b <= adi_gr_pkg::GRID_SIDE - 2; b++)
			for (int a = 1; a <= adi_gr_pkg::GRID_SIDE - 2; a++)
				for (int c = 1; c <= adi_gr_pkg::GRID_SIDE - 2; c++)
					cell_mem[cidx(a, b, c)] = floor_mean(cell_mem[cidx(a, b - 1, c)],
						cell_mem[cidx(a, b + 1, c)]);
		for (int c = 1; c <= adi_gr_pkg::GRID_SIDE - 2; c++)
			for (int a = 1; a <= adi_gr_pkg::GRID_SIDE - 2; a++)
				for (int b = 1; b <= adi_gr_pkg::GRID_SIDE - 2; b++) begin
					p = cidx(a, b, c);
					old_v = cell_mem[p];
					new_v = floor_mean(cell_mem[cidx(a, b, c - 1)], cell_mem[cidx(a, b, c + 1)]);
					d = old_v - new_v;
					if (d < 0)
						d = -d;
					cell_mem[p] = new_v;
					if (big < d)
						big = d;
				end
		return big;
	endfunction

	// sweeps until below threshold or the limit is hit
	function automatic void model_run();
		longint chg;
		longint chg_max;
		int done;
		bit conv;
		chg = 0;
		done = 0;
		conv = 1'b0;
		chg_max = (longint'(1) << adi_gr_pkg::CHG_W) - 1;
		for (int it = 1; it <= int'(limit_shadow) && !conv; it++) begin
			chg = model_sweep();
			done = it;
			if (chg < longint'(thr_shadow))
				conv = 1'b1;
		end
		run_iters = conv ? adi_gr_pkg::ITER_W'(done) : limit_shadow;
		run_change = (chg > chg_max) ? adi_gr_pkg::CHG_W'(chg_max) : adi_gr_pkg::CHG_W'(chg);
		run_conv = conv;
	endfunction

	// applies one item to the model and returns the reply it should cause
	function automatic grid_reply_t model_grid_item(adi_gr_pkg::opcode_t op,
		logic [adi_gr_pkg::IN_CO_W-1:0] ci, logic [adi_gr_pkg::IN_CO_W-1:0] cj,
		logic [adi_gr_pkg::IN_CO_W-1:0] ck, logic [adi_gr_pkg::CELL_W-1:0] v);
		grid_reply_t r;
		int p;
		p = cidx(int'(ci), int'(cj), int'(ck));
		r.read_value = '0;
		case (op)
			adi_gr_pkg::OP_WRITE: cell_mem[p] = longint'($signed(v));
			adi_gr_pkg::OP_RUN:   model_run();
			adi_gr_pkg::OP_READ:  r.read_value = cell_mem[p][adi_gr_pkg::CELL_W-1:0];
			default: ;
		endcase
		r.iterations = run_iters;
		r.change = run_change;
		r.converged = run_conv;
		return r;
	endfunction

	// ---------------------------------------------------------------- reply side

	// ready with random stall bursts
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else if (!idle_on)
			rsp_ch.ready <= 1'b1;
		else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else
			rsp_ch.ready <= 1'b1;
	end

	// compare each accepted reply with the oldest awaited one
	always @(posedge clk) begin : check_replies
		grid_reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (grid_reply_q.size() == 0) begin
				$error("reply item with nothing awaited");
				mismatches++;
			end else begin
				want = grid_reply_q.pop_front();
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value expected %h got %h", want.read_value, rsp_ch.read_value);
					mismatches++;
				end
				if (rsp_ch.iterations_done !== want.iterations) begin
					$error("iterations_done expected %0d got %0d", want.iterations,
						rsp_ch.iterations_done);
					mismatches++;
				end
				if (rsp_ch.final_change !== want.change) begin
					$error("final_change expected %h got %h", want.change, rsp_ch.final_change);
					mismatches++;
				end
				if (rsp_ch.converged !== want.converged) begin
					$error("converged expected %b got %b", want.converged, rsp_ch.converged);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------- command side

	task automatic send_cell_item(adi_gr_pkg::opcode_t op,
		logic [adi_gr_pkg::IN_CO_W-1:0] ci, logic [adi_gr_pkg::IN_CO_W-1:0] cj,
		logic [adi_gr_pkg::IN_CO_W-1:0] ck, logic [adi_gr_pkg::CELL_W-1:0] v);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.coord_i <= ci;
		cmd_ch.coord_j <= cj;
		cmd_ch.coord_k <= ck;
		cmd_ch.cell_value <= v;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		grid_reply_q.push_back(model_grid_item(op, ci, cj, ck, v));
	endtask

	// stop sending and wait for every awaited reply
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (grid_reply_q.size() != 0)
			@(posedge clk);
	endtask

	// both registers, back to back, only while idle
	task automatic set_relax_limits(logic [adi_gr_pkg::CHG_W-1:0] thr,
		logic [adi_gr_pkg::ITER_W-1:0] lim);
		cfg_wen <= 1'b1;
		cfg_index <= adi_gr_pkg::CFG_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= adi_gr_pkg::CFG_ITER_LIMIT;
		cfg_wdata <= adi_gr_pkg::CHG_W'(lim);
		@(posedge clk);
		cfg_wen <= 1'b0;
		thr_shadow = thr;
		limit_shadow = lim;
	endtask

	function automatic logic [adi_gr_pkg::IN_CO_W-1:0] any_coord();
		return adi_gr_pkg::IN_CO_W'($urandom_range(0, adi_gr_pkg::GRID_SIDE - 1));
	endfunction

	// extremes often, otherwise random; narrow keeps values within a few lsb of zero
	function automatic logic [adi_gr_pkg::CELL_W-1:0] pick_cell_value(bit narrow);
		logic [63:0] raw;
		longint nv;
		raw = {$urandom, $urandom};
		nv = longint'($urandom_range(0, 8)) - 4;
		if (narrow)
			return nv[adi_gr_pkg::CELL_W-1:0];
		case ($urandom_range(0, 7))
			0: return {1'b0, {(adi_gr_pkg::CELL_W-1){1'b1}}};
			1: return {1'b1, {(adi_gr_pkg::CELL_W-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return raw[adi_gr_pkg::CELL_W-1:0];
		endcase
	endfunction

	function automatic logic [adi_gr_pkg::CHG_W-1:0] pick_threshold(bit narrow);
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return raw[adi_gr_pkg::CHG_W-1:0];
			3: return adi_gr_pkg::CHG_W'($urandom_range(1, 64));
			default: return narrow ? adi_gr_pkg::CHG_W'($urandom_range(1, 16))
				: raw[adi_gr_pkg::CHG_W-1:0];
		endcase
	endfunction

	// load every cell, so no run or read ever sees an unwritten one
	task automatic fill_grid(bit flat, logic [adi_gr_pkg::CELL_W-1:0] flat_val, bit narrow);
		for (int a = 0; a < adi_gr_pkg::GRID_SIDE; a++)
			for (int b = 0; b < adi_gr_pkg::GRID_SIDE; b++)
				for (int c = 0; c < adi_gr_pkg::GRID_SIDE; c++)
					send_cell_item(adi_gr_pkg::OP_WRITE, adi_gr_pkg::IN_CO_W'(a),
						adi_gr_pkg::IN_CO_W'(b), adi_gr_pkg::IN_CO_W'(c),
						flat ? flat_val : pick_cell_value(narrow));
	endtask

	// ---------------------------------------------------------------- tests

	// flat grid converges in one sweep, at reset settings and at the widest limit
	task automatic test_uniform_grid();
		fill_grid(1'b1, pick_cell_value(1'b0), 1'b0);
		send_cell_item(adi_gr_pkg::OP_RUN, any_coord(), any_coord(), any_coord(),
			pick_cell_value(1'b0));
		wait_idle();
		set_relax_limits('1, adi_gr_pkg::ITER_W'(1023));
		send_cell_item(adi_gr_pkg::OP_RUN, '1, '1, '1, '1);
	endtask

	// cell value extremes on boundary and interior cells, written and read back
	task automatic test_cell_extremes();
		logic [adi_gr_pkg::CELL_W-1:0] vals [5];
		logic [adi_gr_pkg::IN_CO_W-1:0] ci [5];
		logic [adi_gr_pkg::IN_CO_W-1:0] cj [5];
		logic [adi_gr_pkg::IN_CO_W-1:0] ck [5];
		vals = '{{1'b0, {(adi_gr_pkg::CELL_W-1){1'b1}}}, {1'b1, {(adi_gr_pkg::CELL_W-1){1'b0}}},
			'0, '1, adi_gr_pkg::CELL_W'(64'h1_0000_0000)};
		ci = '{4'd0, 4'd15, 4'd7, 4'd1, 4'd14};
		cj = '{4'd0, 4'd15, 4'd7, 4'd7, 4'd14};
		ck = '{4'd0, 4'd15, 4'd0, 4'd7, 4'd15};
		for (int n = 0; n < 5; n++)
			send_cell_item(adi_gr_pkg::OP_WRITE, ci[n], cj[n], ck[n], vals[n]);
		for (int n = 0; n < 5; n++)
			send_cell_item(adi_gr_pkg::OP_READ, ci[n], cj[n], ck[n], pick_cell_value(1'b0));
	endtask

	// opcode 3 changes nothing and reports the last run
	task automatic test_unused_opcode();
		send_cell_item(adi_gr_pkg::OP_NOP, '1, '1, '1, '1);
		send_cell_item(adi_gr_pkg::OP_NOP, '0, any_coord(), any_coord(), pick_cell_value(1'b0));
	endtask

	// a zero limit runs no sweep at all
	task automatic test_limit_zero();
		wait_idle();
		set_relax_limits(adi_gr_pkg::THRESHOLD_RESET, '0);
		send_cell_item(adi_gr_pkg::OP_RUN, any_coord(), any_coord(), any_coord(), '0);
		send_cell_item(adi_gr_pkg::OP_READ, 4'd7, 4'd7, 4'd7, '0);
	endtask

	// zero threshold never converges, so the run stops at the limit
	task automatic test_limit_reached();
		wait_idle();
		set_relax_limits('0, adi_gr_pkg::ITER_W'(2));
		send_cell_item(adi_gr_pkg::OP_RUN, '0, '0, '0, '0);
		send_cell_item(adi_gr_pkg::OP_READ, 4'd1, 4'd7, 4'd7, '0);
		send_cell_item(adi_gr_pkg::OP_READ, 4'd14, 4'd14, 4'd14, '0);
		send_cell_item(adi_gr_pkg::OP_READ, 4'd0, 4'd7, 4'd7, '0);
	endtask

	// widest threshold with a single sweep
	task automatic test_wide_threshold();
		wait_idle();
		set_relax_limits('1, adi_gr_pkg::ITER_W'(1));
		send_cell_item(adi_gr_pkg::OP_RUN, any_coord(), any_coord(), any_coord(), '1);
		send_cell_item(adi_gr_pkg::OP_READ, 4'd7, 4'd1, 4'd7, '0);
	endtask

	// random loads, reads and no-ops with one run per phase; the second half works on a
	// narrow-valued grid so that runs can converge after a few sweeps
	task automatic test_random_traffic();
		int run_slot;
		int pick;
		bit narrow;
		logic [adi_gr_pkg::ITER_W-1:0] lim;
		narrow = 1'b0;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_idle();
			idle_on = (p < PHASE_COUNT - 2) && (p % 4 != 3);
			if (p == PHASE_COUNT / 2) begin
				narrow = 1'b1;
				fill_grid(1'b0, '0, 1'b1);
				wait_idle();
			end
			lim = ($urandom_range(0, 3) == 0) ? adi_gr_pkg::ITER_W'(3)
				: adi_gr_pkg::ITER_W'($urandom_range(1, 2));
			set_relax_limits(pick_threshold(narrow), lim);
			run_slot = $urandom_range(0, PHASE_ITEMS - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender holds off until the block has caught up
				if (p == 0 && n == PHASE_ITEMS / 2)
					wait_idle();
				pick = $urandom_range(0, 99);
				if (n == run_slot)
					send_cell_item(adi_gr_pkg::OP_RUN, any_coord(), any_coord(), any_coord(),
						pick_cell_value(1'b0));
				else if (pick < 45)
					send_cell_item(adi_gr_pkg::OP_WRITE, any_coord(), any_coord(), any_coord(),
						pick_cell_value(narrow));
				else if (pick < 92)
					send_cell_item(adi_gr_pkg::OP_READ, any_coord(), any_coord(), any_coord(),
						pick_cell_value(1'b0));
				else
					send_cell_item(adi_gr_pkg::OP_NOP, any_coord(), any_coord(), any_coord(),
						pick_cell_value(1'b0));
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = adi_gr_pkg::OP_NOP;
		cmd_ch.coord_i = '0;
		cmd_ch.coord_j = '0;
		cmd_ch.coord_k = '0;
		cmd_ch.cell_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = adi_gr_pkg::CFG_THRESHOLD;
		cfg_wdata = '0;
		thr_shadow = adi_gr_pkg::THRESHOLD_RESET;
		limit_shadow = adi_gr_pkg::ITER_LIMIT_RESET;
		run_iters = '0;
		run_change = '0;
		run_conv = 1'b0;
		foreach (cell_mem[n])
			cell_mem[n] = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_uniform_grid();
		fill_grid(1'b0, '0, 1'b0);
		test_cell_extremes();
		test_unused_opcode();
		test_limit_zero();
		test_limit_reached();
		test_wide_threshold();
		test_random_traffic();

		// drain, then leave room for any stray reply
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
src/adi_gr_pkg.sv
src/adi_gr_if.sv
src/adi_gr_grid_mem.sv
src/adi_gr_sweep.sv
src/adi_grid_relaxation_core.sv
tb/adi_grid_relaxation_core_tb.sv
